// ----- hdl/lacd_pkg.sv -----
// ----------------------------------------------------------------------------
// lacd_pkg
// Shared types and constants for the LRU address cache directory.
// ----------------------------------------------------------------------------
package lacd_pkg;

  localparam int unsigned ADDR_W = 64;
  localparam int unsigned SLOT_W = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_LINK_RD,
    ST_UNLINK_OLDER,
    ST_UNLINK_NEWER,
    ST_LINK_OLD,
    ST_LINK_NEW,
    ST_DONE
  } lacd_state_e;

  // Half-entry write enables of the link memory.
  typedef struct packed {
    logic newer;
    logic older;
  } lacd_link_we_t;

endpackage

// ----- hdl/lacd_key_ram.sv -----
// ----------------------------------------------------------------------------
// lacd_key_ram
// Key store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lacd_key_ram #(
  parameter int unsigned ENTRIES = 256,
  parameter int unsigned IDX_W   = 8
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [IDX_W-1:0]          waddr_i,
  input  logic [lacd_pkg::ADDR_W-1:0] wdata_i,
  input  logic [IDX_W-1:0]          raddr_i,
  output logic [lacd_pkg::ADDR_W-1:0] rdata_o
);
  import lacd_pkg::*;

  logic [ADDR_W-1:0] mem [ENTRIES];
  logic [ADDR_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/lacd_link_ram.sv -----
// ----------------------------------------------------------------------------
// lacd_link_ram
// Newer/older link store; each entry holds both links, written per half.
// ----------------------------------------------------------------------------
module lacd_link_ram #(
  parameter int unsigned ENTRIES = 256,
  parameter int unsigned IDX_W   = 8
) (
  input  logic                    clk_i,
  input  lacd_pkg::lacd_link_we_t we_i,
  input  logic [IDX_W-1:0]        waddr_i,
  input  logic [IDX_W-1:0]        wdata_i,
  input  logic [IDX_W-1:0]        raddr_i,
  output logic [IDX_W-1:0]        rd_newer_o,
  output logic [IDX_W-1:0]        rd_older_o
);
  import lacd_pkg::*;

  // Upper half: newer link, lower half: older link.
  logic [2*IDX_W-1:0] mem [ENTRIES];
  logic [2*IDX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i.newer) begin
      mem[waddr_i][2*IDX_W-1:IDX_W] <= wdata_i;
    end
    if (we_i.older) begin
      mem[waddr_i][IDX_W-1:0] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rd_newer_o = rdata_q[2*IDX_W-1:IDX_W];
  assign rd_older_o = rdata_q[IDX_W-1:0];

endmodule

// ----- hdl/lacd_ctrl.sv -----
// ----------------------------------------------------------------------------
// lacd_ctrl
// Sequencer: scans the key store, then relinks the recency list.
// ----------------------------------------------------------------------------
module lacd_ctrl #(
  parameter int unsigned ENTRIES = 256,
  parameter int unsigned IDX_W   = 8,
  parameter int unsigned CNT_W   = 9
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [lacd_pkg::ADDR_W-1:0] lookup_address_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        hit_o,
  output logic [lacd_pkg::SLOT_W-1:0] slot_o,
  output logic                        reclaimed_o,
  // key memory
  output logic                        key_we_o,
  output logic [IDX_W-1:0]            key_waddr_o,
  output logic [lacd_pkg::ADDR_W-1:0] key_wdata_o,
  output logic [IDX_W-1:0]            key_raddr_o,
  input  logic [lacd_pkg::ADDR_W-1:0] key_rdata_i,
  // link memory
  output lacd_pkg::lacd_link_we_t     link_we_o,
  output logic [IDX_W-1:0]            link_waddr_o,
  output logic [IDX_W-1:0]            link_wdata_o,
  output logic [IDX_W-1:0]            link_raddr_o,
  input  logic [IDX_W-1:0]            link_rd_newer_i,
  input  logic [IDX_W-1:0]            link_rd_older_i
);
  import lacd_pkg::*;

  lacd_state_e state_q, state_d;

  logic [ADDR_W-1:0] addr_q;
  logic [IDX_W-1:0]  scan_q, chk_q, slot_q, newer_q, older_q, mr_q, lr_q;
  logic              chk_vld_q, hit_q, evict_q;
  logic [CNT_W-1:0]  used_q;
  logic              out_valid_q, out_hit_q, out_recl_q;
  logic [SLOT_W-1:0] out_slot_q;

  logic              match, last, full, in_acc, out_load;
  logic [IDX_W-1:0]  fresh_slot;
  logic [IDX_W+SLOT_W-1:0] slot_ext;

  assign in_acc     = in_valid_i && (state_q == ST_IDLE);
  assign match      = chk_vld_q && (key_rdata_i == addr_q);
  assign last       = (used_q == '0) ||
                      (chk_vld_q && ((CNT_W'(chk_q) + CNT_W'(1)) == used_q));
  assign full       = (used_q == CNT_W'(ENTRIES));
  assign fresh_slot = used_q[IDX_W-1:0];
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
  assign slot_ext   = {{SLOT_W{1'b0}}, slot_q};

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (match) begin
          state_d = (chk_q == mr_q) ? ST_DONE : ST_LINK_RD;
        end else if (last) begin
          if (!full) begin
            state_d = (used_q == '0) ? ST_DONE : ST_LINK_OLD;
          end else begin
            state_d = (lr_q == mr_q) ? ST_DONE : ST_LINK_RD;
          end
        end
      end
      ST_LINK_RD:      state_d = ST_UNLINK_OLDER;
      ST_UNLINK_OLDER: state_d = ST_UNLINK_NEWER;
      ST_UNLINK_NEWER: state_d = ST_LINK_OLD;
      ST_LINK_OLD:     state_d = ST_LINK_NEW;
      ST_LINK_NEW:     state_d = ST_DONE;
      ST_DONE: begin
        if (out_load) state_d = ST_IDLE;
      end
      default:         state_d = ST_IDLE;
    endcase
  end

  // Memory controls
  always_comb begin
    key_we_o     = 1'b0;
    key_waddr_o  = fresh_slot;
    key_wdata_o  = addr_q;
    key_raddr_o  = scan_q;
    link_we_o    = '0;
    link_waddr_o = slot_q;
    link_wdata_o = mr_q;
    link_raddr_o = slot_q;
    case (state_q)
      ST_SEARCH: begin
        if (!match && last) begin
          key_we_o    = 1'b1;
          key_waddr_o = full ? lr_q : fresh_slot;
        end
      end
      ST_UNLINK_OLDER: begin
        // older_link[newer] = older
        link_we_o.older = 1'b1;
        link_waddr_o    = link_rd_newer_i;
        link_wdata_o    = link_rd_older_i;
      end
      ST_UNLINK_NEWER: begin
        // newer_link[older] = newer, unless the slot was the back
        link_we_o.newer = (slot_q != lr_q);
        link_waddr_o    = older_q;
        link_wdata_o    = newer_q;
      end
      ST_LINK_OLD: begin
        link_we_o.older = 1'b1;
        link_waddr_o    = slot_q;
        link_wdata_o    = mr_q;
      end
      ST_LINK_NEW: begin
        link_we_o.newer = 1'b1;
        link_waddr_o    = mr_q;
        link_wdata_o    = slot_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      chk_vld_q   <= 1'b0;
      mr_q        <= '0;
      lr_q        <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_SEARCH) begin
        chk_vld_q <= 1'b1;
      end else begin
        chk_vld_q <= 1'b0;
      end
      if (state_q == ST_SEARCH && !match && last) begin
        if (!full) begin
          used_q <= used_q + CNT_W'(1);
          if (used_q == '0) begin
            mr_q <= fresh_slot;
            lr_q <= fresh_slot;
          end
        end
      end
      if (state_q == ST_UNLINK_NEWER && slot_q == lr_q) begin
        lr_q <= newer_q;
      end
      if (state_q == ST_LINK_NEW) begin
        mr_q <= slot_q;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      addr_q  <= lookup_address_i;
      scan_q  <= '0;
      hit_q   <= 1'b0;
      evict_q <= 1'b0;
    end
    if (state_q == ST_SEARCH) begin
      // advance the scan; read data arrives in the cycle after its address
      scan_q <= scan_q + IDX_W'(1);
      chk_q  <= scan_q;
      if (match) begin
        slot_q <= chk_q;
        hit_q  <= 1'b1;
      end else if (last) begin
        slot_q  <= full ? lr_q : fresh_slot;
        evict_q <= full;
      end
    end
    if (state_q == ST_UNLINK_OLDER) begin
      newer_q <= link_rd_newer_i;
      older_q <= link_rd_older_i;
    end
    if (out_load) begin
      out_hit_q  <= hit_q;
      out_slot_q <= slot_ext[SLOT_W-1:0];
      out_recl_q <= evict_q;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign hit_o       = out_hit_q;
  assign slot_o      = out_slot_q;
  assign reclaimed_o = out_recl_q;

endmodule

// ----- hdl/lru_address_cache_directory_top.sv -----
// ----------------------------------------------------------------------------
// lru_address_cache_directory_top
// Fully associative address directory kept in most-recently-used order.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Beat
//  in        input      in_valid_i / in_stall_o   lookup_address_i
//  out       output     out_valid_o / out_stall_i hit_o, slot_o, reclaimed_o
//
//  Sequence: a scan of the used slots in order until a hit or the last one,
//  then 2 link writes for a fresh fill of a non-empty list, or a read,
//  unlink and relink to move a slot to the front, then the result is loaded;
//  the block returns to idle before it takes the next lookup.
//  Reset empties the directory at once; no clearing pass is needed.
//  A result held under out_stall_i stalls only the next result's hand-off.
// ----------------------------------------------------------------------------
module lru_address_cache_directory_top #(
  parameter int unsigned ENTRIES = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [lacd_pkg::ADDR_W-1:0] lookup_address_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        hit_o,
  output logic [lacd_pkg::SLOT_W-1:0] slot_o,
  output logic                        reclaimed_o
);
  import lacd_pkg::*;

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  logic              key_we;
  logic [IDX_W-1:0]  key_waddr, key_raddr;
  logic [ADDR_W-1:0] key_wdata, key_rdata;
  lacd_link_we_t     link_we;
  logic [IDX_W-1:0]  link_waddr, link_wdata, link_raddr, link_rd_newer, link_rd_older;

  lacd_key_ram #(.ENTRIES(ENTRIES), .IDX_W(IDX_W)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_wdata),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  lacd_link_ram #(.ENTRIES(ENTRIES), .IDX_W(IDX_W)) u_link_ram (
    .clk_i      (clk_i),
    .we_i       (link_we),
    .waddr_i    (link_waddr),
    .wdata_i    (link_wdata),
    .raddr_i    (link_raddr),
    .rd_newer_o (link_rd_newer),
    .rd_older_o (link_rd_older)
  );

  lacd_ctrl #(.ENTRIES(ENTRIES), .IDX_W(IDX_W), .CNT_W(CNT_W)) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .lookup_address_i (lookup_address_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .hit_o            (hit_o),
    .slot_o           (slot_o),
    .reclaimed_o      (reclaimed_o),
    .key_we_o         (key_we),
    .key_waddr_o      (key_waddr),
    .key_wdata_o      (key_wdata),
    .key_raddr_o      (key_raddr),
    .key_rdata_i      (key_rdata),
    .link_we_o        (link_we),
    .link_waddr_o     (link_waddr),
    .link_wdata_o     (link_wdata),
    .link_raddr_o     (link_raddr),
    .link_rd_newer_i  (link_rd_newer),
    .link_rd_older_i  (link_rd_older)
  );

endmodule
